@@ rtl/core/hkd_pkg.sv @@
// Shared types, key codes and character tables for the HID key decoder.
package hkd_pkg;

    localparam logic [7:0] MASK_SHIFT = 8'h22;
    localparam logic [7:0] MASK_CTRL  = 8'h11;
    localparam logic [7:0] MASK_ALT   = 8'h44;

    localparam logic [7:0] TABLE_LEN  = 8'h39;

    localparam logic [7:0] KEY_A       = 8'h04;
    localparam logic [7:0] KEY_B       = 8'h05;
    localparam logic [7:0] KEY_E       = 8'h08;
    localparam logic [7:0] KEY_F       = 8'h09;
    localparam logic [7:0] KEY_N       = 8'h11;
    localparam logic [7:0] KEY_P       = 8'h13;
    localparam logic [7:0] KEY_Y       = 8'h1C;
    localparam logic [7:0] KEY_Z       = 8'h1D;
    localparam logic [7:0] KEY_ENTER   = 8'h28;
    localparam logic [7:0] KEY_BKSP    = 8'h2A;
    localparam logic [7:0] KEY_DEL     = 8'h4C;
    localparam logic [7:0] ARROW_RIGHT = 8'h4F;
    localparam logic [7:0] ARROW_LEFT  = 8'h50;
    localparam logic [7:0] ARROW_DOWN  = 8'h51;
    localparam logic [7:0] ARROW_UP    = 8'h52;

    localparam logic [6:0] CHAR_NEWLINE = 7'h0A;

    typedef enum logic [3:0] {
        EV_INSERT     = 4'd0,
        EV_BACKSPACE  = 4'd1,
        EV_DELETE     = 4'd2,
        EV_LEFT       = 4'd3,
        EV_RIGHT      = 4'd4,
        EV_UP         = 4'd5,
        EV_DOWN       = 4'd6,
        EV_WORD_LEFT  = 4'd7,
        EV_WORD_RIGHT = 4'd8,
        EV_LINE_START = 4'd9,
        EV_LINE_END   = 4'd10,
        EV_UNDO       = 4'd11,
        EV_REDO       = 4'd12
    } t_event_kind;

    typedef struct packed {
        logic        valid;
        t_event_kind kind;
        logic [6:0]  char_code;
        logic        char_count;
    } t_event;

    // US layout, no shift; codes below TABLE_LEN
    function automatic logic [6:0] plain_char(input logic [5:0] code);
        logic [6:0] ch;
        ch = 7'h00;
        if (code >= KEY_A[5:0] && code <= KEY_Z[5:0]) begin
            ch = 7'h5D + {1'b0, code};
        end else begin
            case (code)
                6'h1E: ch = 7'h31;
                6'h1F: ch = 7'h32;
                6'h20: ch = 7'h33;
                6'h21: ch = 7'h34;
                6'h22: ch = 7'h35;
                6'h23: ch = 7'h36;
                6'h24: ch = 7'h37;
                6'h25: ch = 7'h38;
                6'h26: ch = 7'h39;
                6'h27: ch = 7'h30;
                6'h2C: ch = 7'h20;
                6'h2D: ch = 7'h2D;
                6'h2E: ch = 7'h3D;
                6'h2F: ch = 7'h5B;
                6'h30: ch = 7'h5D;
                6'h31: ch = 7'h5C;
                6'h33: ch = 7'h3B;
                6'h34: ch = 7'h27;
                6'h35: ch = 7'h60;
                6'h36: ch = 7'h2C;
                6'h37: ch = 7'h2E;
                6'h38: ch = 7'h2F;
                default: ch = 7'h00;
            endcase
        end
        return ch;
    endfunction

    // US layout with shift
    function automatic logic [6:0] upper_char(input logic [5:0] code);
        logic [6:0] ch;
        ch = 7'h00;
        if (code >= KEY_A[5:0] && code <= KEY_Z[5:0]) begin
            ch = 7'h3D + {1'b0, code};
        end else begin
            case (code)
                6'h1E: ch = 7'h21;
                6'h1F: ch = 7'h40;
                6'h20: ch = 7'h23;
                6'h21: ch = 7'h24;
                6'h22: ch = 7'h25;
                6'h23: ch = 7'h5E;
                6'h24: ch = 7'h26;
                6'h25: ch = 7'h2A;
                6'h26: ch = 7'h28;
                6'h27: ch = 7'h29;
                6'h2C: ch = 7'h20;
                6'h2D: ch = 7'h5F;
                6'h2E: ch = 7'h2B;
                6'h2F: ch = 7'h7B;
                6'h30: ch = 7'h7D;
                6'h31: ch = 7'h7C;
                6'h33: ch = 7'h3A;
                6'h34: ch = 7'h22;
                6'h35: ch = 7'h7E;
                6'h36: ch = 7'h3C;
                6'h37: ch = 7'h3E;
                6'h38: ch = 7'h3F;
                default: ch = 7'h00;
            endcase
        end
        return ch;
    endfunction

endpackage

@@ rtl/core/hid_key_to_ascii_decoder.sv @@
// Top level of the HID key to editor event decoder.
// An accepted request passes the input register, then the result register, which
// shows its event with o_strobe.
// Throughput: one request per cycle; o_busy is always low.
// Reset: synchronous active-low i_rst_n clears both stage valid flags.
// The receiver cannot stall; each event is shown for exactly one cycle.
module hid_key_to_ascii_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic [7:0] i_modifiers,
    input  logic [7:0] i_usage_code,
    input  logic       i_caps_on,
    output logic       o_strobe,
    output logic       o_event_valid,
    output logic [3:0] o_event_kind,
    output logic [6:0] o_char_code,
    output logic       o_char_count
);

    logic            r_in_valid;
    logic [7:0]      r_modifiers;
    logic [7:0]      r_usage_code;
    logic            r_caps_on;
    logic            r_out_valid;
    hkd_pkg::t_event r_event;
    hkd_pkg::t_event n_event;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= i_start && !o_busy;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_modifiers  <= i_modifiers;
        r_usage_code <= i_usage_code;
        r_caps_on    <= i_caps_on;
        r_event      <= n_event;
    end

    hkd_decode u_decode (
        .i_modifiers  (r_modifiers),
        .i_usage_code (r_usage_code),
        .i_caps_on    (r_caps_on),
        .o_event      (n_event)
    );

    assign o_strobe      = r_out_valid;
    assign o_event_valid = r_event.valid;
    assign o_event_kind  = r_event.kind;
    assign o_char_code   = r_event.char_code;
    assign o_char_count  = r_event.char_count;

    a_request_gives_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_strobe)
        else $error("accepted request did not give an event");

    a_no_event_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_event_valid) |->
        (o_event_kind == 4'd0 && o_char_code == 7'd0 && o_char_count == 1'b0))
        else $error("swallowed key left nonzero fields");

    a_count_matches_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |->
        (o_char_count == (o_event_valid && o_event_kind == hkd_pkg::EV_INSERT)))
        else $error("char_count disagrees with event kind");

    a_insert_has_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_char_count) |-> (o_char_code != 7'd0))
        else $error("insert event without a character");

    a_other_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_char_count) |-> (o_char_code == 7'd0))
        else $error("non-insert event carries a character");

endmodule

@@ rtl/core/hkd_decode.sv @@
// Priority decode of one registered key request into an editor event.
module hkd_decode (
    input  logic [7:0]     i_modifiers,
    input  logic [7:0]     i_usage_code,
    input  logic           i_caps_on,
    output hkd_pkg::t_event o_event
);

    logic       word;
    logic       alt;
    logic       ctrl;
    logic       is_letter;
    logic       shift;
    logic [6:0] ch;

    assign alt       = |(i_modifiers & hkd_pkg::MASK_ALT);
    assign ctrl      = |(i_modifiers & hkd_pkg::MASK_CTRL);
    assign word      = alt | ctrl;
    assign is_letter = (i_usage_code >= hkd_pkg::KEY_A) && (i_usage_code <= hkd_pkg::KEY_Z);
    assign shift     = (|(i_modifiers & hkd_pkg::MASK_SHIFT)) ^ (i_caps_on & is_letter);
    assign ch        = shift ? hkd_pkg::upper_char(i_usage_code[5:0])
                             : hkd_pkg::plain_char(i_usage_code[5:0]);

    always_comb begin
        o_event = '0;
        case (i_usage_code)
            hkd_pkg::KEY_ENTER: begin
                o_event.valid     = 1'b1;
                o_event.kind      = hkd_pkg::EV_INSERT;
                o_event.char_code = hkd_pkg::CHAR_NEWLINE;
            end
            hkd_pkg::KEY_BKSP: begin
                o_event.valid = 1'b1;
                o_event.kind  = hkd_pkg::EV_BACKSPACE;
            end
            hkd_pkg::KEY_DEL: begin
                o_event.valid = 1'b1;
                o_event.kind  = hkd_pkg::EV_DELETE;
            end
            hkd_pkg::ARROW_RIGHT: begin
                o_event.valid = 1'b1;
                o_event.kind  = word ? hkd_pkg::EV_WORD_RIGHT : hkd_pkg::EV_RIGHT;
            end
            hkd_pkg::ARROW_LEFT: begin
                o_event.valid = 1'b1;
                o_event.kind  = word ? hkd_pkg::EV_WORD_LEFT : hkd_pkg::EV_LEFT;
            end
            hkd_pkg::ARROW_DOWN: begin
                o_event.valid = 1'b1;
                o_event.kind  = hkd_pkg::EV_DOWN;
            end
            hkd_pkg::ARROW_UP: begin
                o_event.valid = 1'b1;
                o_event.kind  = hkd_pkg::EV_UP;
            end
            default: begin
                if (alt) begin
                    if (i_usage_code == hkd_pkg::KEY_F) begin
                        o_event.valid = 1'b1;
                        o_event.kind  = hkd_pkg::EV_WORD_RIGHT;
                    end else if (i_usage_code == hkd_pkg::KEY_B) begin
                        o_event.valid = 1'b1;
                        o_event.kind  = hkd_pkg::EV_WORD_LEFT;
                    end
                end else if (ctrl) begin
                    o_event.valid = 1'b1;
                    case (i_usage_code)
                        hkd_pkg::KEY_A: o_event.kind = hkd_pkg::EV_LINE_START;
                        hkd_pkg::KEY_E: o_event.kind = hkd_pkg::EV_LINE_END;
                        hkd_pkg::KEY_P: o_event.kind = hkd_pkg::EV_UP;
                        hkd_pkg::KEY_N: o_event.kind = hkd_pkg::EV_DOWN;
                        hkd_pkg::KEY_B: o_event.kind = hkd_pkg::EV_LEFT;
                        hkd_pkg::KEY_F: o_event.kind = hkd_pkg::EV_RIGHT;
                        hkd_pkg::KEY_Z: o_event.kind = hkd_pkg::EV_UNDO;
                        hkd_pkg::KEY_Y: o_event.kind = hkd_pkg::EV_REDO;
                        default:        o_event.valid = 1'b0;
                    endcase
                end else if (i_usage_code < hkd_pkg::TABLE_LEN && ch != 7'h00) begin
                    o_event.valid     = 1'b1;
                    o_event.kind      = hkd_pkg::EV_INSERT;
                    o_event.char_code = ch;
                end
            end
        endcase
        o_event.char_count = o_event.valid && (o_event.kind == hkd_pkg::EV_INSERT);
    end

endmodule

@@ test/hid_key_to_ascii_decoder_checker.sv @@
// Checker for the HID key decoder: predicts each editor event and compares.
`timescale 1ns / 100ps

module hid_key_to_ascii_decoder_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  logic [7:0] i_modifiers,
    input  logic [7:0] i_usage_code,
    input  logic       i_caps_on,
    input  logic       i_strobe,
    input  logic       i_event_valid,
    input  logic [3:0] i_event_kind,
    input  logic [6:0] i_char_code,
    input  logic       i_char_count,
    output int         o_mismatches,
    output int         o_pending,
    output int         o_requests,
    output int         o_inserts,
    output int         o_no_events
);

    hkd_pkg::t_event expected_events[$];

    // US layout character for a usage code below the table end, 0 if none
    function automatic logic [6:0] us_key_char(input logic [7:0] code, input logic shifted);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h00;
        hi = 8'h00;
        if (code >= hkd_pkg::KEY_A && code <= hkd_pkg::KEY_Z) begin
            lo = "a" + (code - hkd_pkg::KEY_A);
            hi = "A" + (code - hkd_pkg::KEY_A);
        end else begin
            case (code)
                8'h1E: {lo, hi} = "1!";
                8'h1F: {lo, hi} = "2@";
                8'h20: {lo, hi} = "3#";
                8'h21: {lo, hi} = "4$";
                8'h22: {lo, hi} = "5%";
                8'h23: {lo, hi} = "6^";
                8'h24: {lo, hi} = "7&";
                8'h25: {lo, hi} = "8*";
                8'h26: {lo, hi} = "9(";
                8'h27: {lo, hi} = "0)";
                8'h2C: {lo, hi} = "  ";
                8'h2D: {lo, hi} = "-_";
                8'h2E: {lo, hi} = "=+";
                8'h2F: {lo, hi} = "[{";
                8'h30: {lo, hi} = "]}";
                8'h31: {lo, hi} = "\\|";
                8'h33: {lo, hi} = ";:";
                8'h34: {lo, hi} = "'\"";
                8'h35: {lo, hi} = "`~";
                8'h36: {lo, hi} = ",<";
                8'h37: {lo, hi} = ".>";
                8'h38: {lo, hi} = "/?";
                default: {lo, hi} = 16'h0000;
            endcase
        end
        return shifted ? hi[6:0] : lo[6:0];
    endfunction

    function automatic hkd_pkg::t_event decode_key_event(input logic [7:0] mods,
                                                         input logic [7:0] code,
                                                         input logic caps);
        hkd_pkg::t_event ev;
        logic            word;
        logic            shifted;
        logic [6:0]      ch;
        ev = '0;
        ev.valid = 1'b1;
        word = |(mods & (hkd_pkg::MASK_CTRL | hkd_pkg::MASK_ALT));
        case (code)
            hkd_pkg::KEY_ENTER: begin
                ev.kind = hkd_pkg::EV_INSERT;
                ev.char_code = hkd_pkg::CHAR_NEWLINE;
            end
            hkd_pkg::KEY_BKSP:    ev.kind = hkd_pkg::EV_BACKSPACE;
            hkd_pkg::KEY_DEL:     ev.kind = hkd_pkg::EV_DELETE;
            hkd_pkg::ARROW_RIGHT: ev.kind = word ? hkd_pkg::EV_WORD_RIGHT : hkd_pkg::EV_RIGHT;
            hkd_pkg::ARROW_LEFT:  ev.kind = word ? hkd_pkg::EV_WORD_LEFT : hkd_pkg::EV_LEFT;
            hkd_pkg::ARROW_DOWN:  ev.kind = hkd_pkg::EV_DOWN;
            hkd_pkg::ARROW_UP:    ev.kind = hkd_pkg::EV_UP;
            default: begin
                if (|(mods & hkd_pkg::MASK_ALT)) begin
                    if (code == hkd_pkg::KEY_F) ev.kind = hkd_pkg::EV_WORD_RIGHT;
                    else if (code == hkd_pkg::KEY_B) ev.kind = hkd_pkg::EV_WORD_LEFT;
                    else ev.valid = 1'b0;
                end else if (|(mods & hkd_pkg::MASK_CTRL)) begin
                    case (code)
                        hkd_pkg::KEY_A: ev.kind = hkd_pkg::EV_LINE_START;
                        hkd_pkg::KEY_E: ev.kind = hkd_pkg::EV_LINE_END;
                        hkd_pkg::KEY_P: ev.kind = hkd_pkg::EV_UP;
                        hkd_pkg::KEY_N: ev.kind = hkd_pkg::EV_DOWN;
                        hkd_pkg::KEY_B: ev.kind = hkd_pkg::EV_LEFT;
                        hkd_pkg::KEY_F: ev.kind = hkd_pkg::EV_RIGHT;
                        hkd_pkg::KEY_Z: ev.kind = hkd_pkg::EV_UNDO;
                        hkd_pkg::KEY_Y: ev.kind = hkd_pkg::EV_REDO;
                        default:        ev.valid = 1'b0;
                    endcase
                end else begin
                    shifted = |(mods & hkd_pkg::MASK_SHIFT);
                    if (caps && code >= hkd_pkg::KEY_A && code <= hkd_pkg::KEY_Z) begin
                        shifted = !shifted;
                    end
                    ch = (code < hkd_pkg::TABLE_LEN) ? us_key_char(code, shifted) : 7'h00;
                    if (ch == 7'h00) begin
                        ev.valid = 1'b0;
                    end else begin
                        ev.kind = hkd_pkg::EV_INSERT;
                        ev.char_code = ch;
                    end
                end
            end
        endcase
        if (!ev.valid) ev = '0;
        ev.char_count = ev.valid && ev.kind == hkd_pkg::EV_INSERT && ev.char_code != 7'h00;
        return ev;
    endfunction

    task automatic report_field(input string field, input int exp_val, input int got_val);
        if (exp_val != got_val) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_val, got_val);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        hkd_pkg::t_event exp_ev;
        if (!i_rst_n) begin
            expected_events.delete();
            o_mismatches = 0;
            o_pending = 0;
            o_requests = 0;
            o_inserts = 0;
            o_no_events = 0;
        end else begin
            if (i_strobe) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected event, expected none, got valid %0b kind %0d char %0h",
                             $time, i_event_valid, i_event_kind, i_char_code);
                    o_mismatches++;
                end else begin
                    exp_ev = expected_events.pop_front();
                    report_field("event_valid", exp_ev.valid, i_event_valid);
                    report_field("event_kind", exp_ev.kind, i_event_kind);
                    report_field("char_code", exp_ev.char_code, i_char_code);
                    report_field("char_count", exp_ev.char_count, i_char_count);
                end
            end
            if (i_start && !i_busy) begin
                exp_ev = decode_key_event(i_modifiers, i_usage_code, i_caps_on);
                expected_events.push_back(exp_ev);
                o_requests++;
                if (!exp_ev.valid) o_no_events++;
                else if (exp_ev.kind == hkd_pkg::EV_INSERT) o_inserts++;
            end
            o_pending = expected_events.size();
        end
    end

endmodule

@@ test/hid_key_to_ascii_decoder_tb.sv @@
// Testbench top for the HID key decoder: stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module hid_key_to_ascii_decoder_tb;

    localparam int RANDOM_KEYS  = 550;
    localparam int CALM_TAIL    = 100;
    localparam int STALL_LIMIT  = 500;
    localparam int DRAIN_CYCLES = 4;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    logic       o_busy;
    logic [7:0] i_modifiers;
    logic [7:0] i_usage_code;
    logic       i_caps_on;
    logic       o_strobe;
    logic       o_event_valid;
    logic [3:0] o_event_kind;
    logic [6:0] o_char_code;
    logic       o_char_count;

    int mismatches;
    int pending;
    int requests;
    int inserts;
    int no_events;
    int stall_cycles;
    int directed_keys;

    logic [7:0] fixed_keys [7] = '{hkd_pkg::KEY_ENTER, hkd_pkg::KEY_BKSP, hkd_pkg::KEY_DEL,
                                   hkd_pkg::ARROW_RIGHT, hkd_pkg::ARROW_LEFT,
                                   hkd_pkg::ARROW_DOWN, hkd_pkg::ARROW_UP};
    logic [7:0] cmd_keys   [8] = '{hkd_pkg::KEY_A, hkd_pkg::KEY_B, hkd_pkg::KEY_E,
                                   hkd_pkg::KEY_F, hkd_pkg::KEY_N, hkd_pkg::KEY_P,
                                   hkd_pkg::KEY_Y, hkd_pkg::KEY_Z};

    hid_key_to_ascii_decoder u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_modifiers  (i_modifiers),
        .i_usage_code (i_usage_code),
        .i_caps_on    (i_caps_on),
        .o_strobe     (o_strobe),
        .o_event_valid(o_event_valid),
        .o_event_kind (o_event_kind),
        .o_char_code  (o_char_code),
        .o_char_count (o_char_count)
    );

    hid_key_to_ascii_decoder_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_modifiers  (i_modifiers),
        .i_usage_code (i_usage_code),
        .i_caps_on    (i_caps_on),
        .i_strobe     (o_strobe),
        .i_event_valid(o_event_valid),
        .i_event_kind (o_event_kind),
        .i_char_code  (o_char_code),
        .i_char_count (o_char_count),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_requests   (requests),
        .o_inserts    (inserts),
        .o_no_events  (no_events)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // no progress on either side for too long ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_strobe) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("hid_key_to_ascii_decoder_tb: FAIL");
                $finish;
            end
        end
    end

    // called at a rising edge; returns at the edge that takes the request
    task automatic send_key(input logic [7:0] mods, input logic [7:0] code, input logic caps);
        i_start <= 1'b1;
        i_modifiers <= mods;
        i_usage_code <= code;
        i_caps_on <= caps;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic pause_requests(input int cycles);
        i_start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_modifiers();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'($urandom) & (hkd_pkg::MASK_SHIFT | 8'h88);
            2:       return 8'($urandom) & ~hkd_pkg::MASK_ALT;
            3:       return 8'($urandom) & (hkd_pkg::MASK_ALT | hkd_pkg::MASK_SHIFT);
            4:       return hkd_pkg::MASK_CTRL & 8'($urandom);
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_usage_code();
        case ($urandom_range(0, 4))
            0, 1:    return 8'($urandom_range(0, hkd_pkg::TABLE_LEN - 1));
            2:       return fixed_keys[3'($urandom_range(0, 6))];
            3:       return cmd_keys[3'($urandom_range(0, 7))];
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_modifiers = 8'h00;
        i_usage_code = 8'h00;
        i_caps_on = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fixed keys, with and without modifiers
        send_key(8'h00, hkd_pkg::KEY_ENTER, 1'b0);
        send_key(8'hFF, hkd_pkg::KEY_ENTER, 1'b1);
        send_key(8'h00, hkd_pkg::KEY_BKSP, 1'b0);
        send_key(8'h00, hkd_pkg::KEY_DEL, 1'b0);
        send_key(8'h00, hkd_pkg::ARROW_RIGHT, 1'b0);
        send_key(8'h10, hkd_pkg::ARROW_LEFT, 1'b0);
        send_key(8'h40, hkd_pkg::ARROW_RIGHT, 1'b0);
        send_key(8'h00, hkd_pkg::ARROW_DOWN, 1'b0);
        send_key(8'h00, hkd_pkg::ARROW_UP, 1'b0);
        // alt word moves and swallow
        send_key(8'h04, hkd_pkg::KEY_F, 1'b0);
        send_key(8'h40, hkd_pkg::KEY_B, 1'b0);
        send_key(8'h44, hkd_pkg::KEY_A, 1'b0);
        // ctrl commands and swallow
        send_key(8'h01, hkd_pkg::KEY_A, 1'b0);
        send_key(8'h10, hkd_pkg::KEY_E, 1'b0);
        send_key(8'h01, hkd_pkg::KEY_P, 1'b0);
        send_key(8'h10, hkd_pkg::KEY_N, 1'b0);
        send_key(8'h01, hkd_pkg::KEY_B, 1'b0);
        send_key(8'h10, hkd_pkg::KEY_F, 1'b0);
        send_key(8'h11, hkd_pkg::KEY_Z, 1'b1);
        send_key(8'h01, hkd_pkg::KEY_Y, 1'b0);
        send_key(8'h01, 8'h1E, 1'b0);
        // caps lock: letters only, inverts shift
        send_key(8'h00, hkd_pkg::KEY_A, 1'b1);
        send_key(8'h22, hkd_pkg::KEY_Z, 1'b1);
        send_key(8'h02, 8'h1E, 1'b1);
        // no table entry, GUI bits ignored
        send_key(8'h00, 8'h00, 1'b0);
        send_key(8'h88, hkd_pkg::TABLE_LEN - 8'h01, 1'b0);
        send_key(8'h00, hkd_pkg::TABLE_LEN, 1'b0);
        send_key(8'h00, 8'hFF, 1'b1);
        directed_keys = 28;

        for (int n = 0; n < RANDOM_KEYS; n++) begin
            if (n == RANDOM_KEYS / 2) begin
                wait_drained();
            end else if (n < RANDOM_KEYS - CALM_TAIL && $urandom_range(0, 5) == 0) begin
                pause_requests($urandom_range(1, 13));
            end
            send_key(pick_modifiers(), pick_usage_code(), 1'($urandom_range(0, 1)));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d key requests (%0d directed, %0d random).",
                 requests, directed_keys, requests - directed_keys);
        $display("Events: %0d inserts, %0d no-event results, %0d mismatches.",
                 inserts, no_events, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("hid_key_to_ascii_decoder_tb: PASS");
        end else begin
            $display("hid_key_to_ascii_decoder_tb: FAIL");
        end
        $finish;
    end

endmodule
